// ----- design/bti_pkg.sv -----
package bti_pkg;

  localparam int ALT_BITS   = 14;
  localparam int TEMP_BITS  = 7;
  localparam int RATE_BITS  = 18;
  localparam int ENTRY_BITS = 10;
  localparam int GRID_BITS  = 4;
  localparam int FA_BITS    = 11;
  localparam int FT_BITS    = 5;

  localparam int ALT_STEP  = 2000;
  localparam int TEMP_STEP = 20;
  localparam int TEMP_BASE = -20;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // classified query as it travels from front to back
  typedef struct packed {
    logic                 oor;
    logic [GRID_BITS-1:0] row;
    logic [GRID_BITS-1:0] col;
    logic [FA_BITS-1:0]   fa;
    logic [FT_BITS-1:0]   ft;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // fixed climb chart, rows are altitude, columns temperature; unused cells read zero
  function automatic logic [ENTRY_BITS-1:0] climb_entry(
    input logic [GRID_BITS-1:0] r,
    input logic [GRID_BITS-1:0] c
  );
    logic [ENTRY_BITS-1:0] v;
    unique case ({r, c})
      8'h00: v = 10'd830;
      8'h01: v = 10'd770;
      8'h02: v = 10'd705;
      8'h03: v = 10'd640;
      8'h10: v = 10'd720;
      8'h11: v = 10'd655;
      8'h12: v = 10'd595;
      8'h13: v = 10'd535;
      8'h20: v = 10'd645;
      8'h21: v = 10'd585;
      8'h22: v = 10'd525;
      8'h23: v = 10'd465;
      8'h30: v = 10'd530;
      8'h31: v = 10'd475;
      8'h32: v = 10'd415;
      8'h33: v = 10'd360;
      8'h40: v = 10'd420;
      8'h41: v = 10'd365;
      8'h42: v = 10'd310;
      8'h43: v = 10'd250;
      8'h50: v = 10'd310;
      8'h51: v = 10'd255;
      8'h52: v = 10'd200;
      8'h53: v = 10'd145;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/bti_in_if.sv -----
interface bti_in_if import bti_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [ALT_BITS-1:0]         altitude;
  logic signed [TEMP_BITS-1:0] temperature;

  modport source (output valid, altitude, temperature, input ready);
  modport sink (input valid, altitude, temperature, output ready);
endinterface

// ----- design/bti_out_if.sv -----
interface bti_out_if import bti_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [RATE_BITS-1:0] climb_rate;
  logic                 out_of_range;

  modport source (output valid, climb_rate, out_of_range, input ready);
  modport sink (input valid, climb_rate, out_of_range, output ready);
endinterface

// ----- design/bti_front.sv -----
module bti_front import bti_pkg::*; #(
  parameter int ALT_ROWS  = 6,
  parameter int TEMP_COLS = 4
) (
  input  logic         clk,
  input  logic         rst,
  bti_in_if.sink       in_ch,
  input  q_stat_t      q_stat,
  output logic         push,
  output item_t        push_item
);

  // floor(alt / 2000) as (alt * ceil(2^25 / 2000)) >> 25, exact for 14-bit alt
  localparam int ALT_SHIFT = 25;
  localparam logic [14:0] ALT_RECIP = 15'((2 ** ALT_SHIFT + ALT_STEP - 1) / ALT_STEP);
  // floor(tu / 20) as (tu * ceil(2^11 / 20)) >> 11, exact for 7-bit tu
  localparam int TMP_SHIFT = 11;
  localparam logic [6:0] TMP_RECIP = 7'((2 ** TMP_SHIFT + TEMP_STEP - 1) / TEMP_STEP);

  localparam logic [15:0] ALT_TOP = 16'((ALT_ROWS - 1) * ALT_STEP);
  localparam logic signed [9:0] TEMP_TOP = 10'((TEMP_COLS - 1) * TEMP_STEP);
  localparam logic signed [9:0] TEMP_OFS = 10'(-TEMP_BASE);
  localparam logic [GRID_BITS-1:0] ROW_MAX = GRID_BITS'(ALT_ROWS - 2);
  localparam logic [GRID_BITS-1:0] COL_MAX = GRID_BITS'(TEMP_COLS - 2);

  logic                 f1_valid;
  logic [ALT_BITS-1:0]  f1_alt;
  logic [6:0]           f1_tu;
  logic [3:0]           f1_row_raw;
  logic [2:0]           f1_col_raw;
  logic                 f1_oor;

  logic signed [9:0]    toff;
  logic [28:0]          alt_prod;
  logic [13:0]          tmp_prod;
  logic                 oor;

  logic [GRID_BITS-1:0] row;
  logic [GRID_BITS-1:0] col;
  logic [14:0]          row_base;
  logic [14:0]          fa_full;
  logic [8:0]           col_base;
  logic [8:0]           ft_full;

  assign toff     = {{(10 - TEMP_BITS){in_ch.temperature[TEMP_BITS-1]}}, in_ch.temperature}
                    + TEMP_OFS;
  assign oor      = ({2'b00, in_ch.altitude} > ALT_TOP) || (toff < 10'sd0) || (toff > TEMP_TOP);
  assign alt_prod = 29'(in_ch.altitude) * 29'(ALT_RECIP);
  assign tmp_prod = 14'(toff[6:0]) * 14'(TMP_RECIP);

  assign push        = f1_valid && !q_stat.full;
  assign in_ch.ready = !f1_valid || push;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      f1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      f1_alt     <= in_ch.altitude;
      f1_tu      <= toff[6:0];
      f1_row_raw <= alt_prod[ALT_SHIFT+3:ALT_SHIFT];
      f1_col_raw <= tmp_prod[TMP_SHIFT+2:TMP_SHIFT];
      f1_oor     <= oor;
    end
  end

  // clamp to the last cell at the top edge and form the fractions
  always_comb begin
    row      = (f1_row_raw > ROW_MAX) ? ROW_MAX : f1_row_raw;
    col      = ({1'b0, f1_col_raw} > COL_MAX) ? COL_MAX : {1'b0, f1_col_raw};
    row_base = 15'(row) * 15'(ALT_STEP);
    fa_full  = {1'b0, f1_alt} - row_base;
    col_base = 9'(col) * 9'(TEMP_STEP);
    ft_full  = {2'b00, f1_tu} - col_base;

    push_item.oor = f1_oor;
    push_item.row = row;
    push_item.col = col;
    push_item.fa  = fa_full[FA_BITS-1:0];
    push_item.ft  = ft_full[FT_BITS-1:0];
  end

endmodule

// ----- design/bti_queue.sv -----
module bti_queue import bti_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  item_t   push_item,
  input  logic    pop,
  output item_t   head,
  output q_stat_t q_stat
);

  item_t                mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
    return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head         = mem[rd_ptr];
  assign q_stat.full  = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- design/bti_back.sv -----
module bti_back import bti_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  item_t   head,
  input  q_stat_t q_stat,
  output logic    pop,
  bti_out_if.source out_ch
);

  // (256*sum + 20000) / 40000 == (4*sum + 312) / 625
  localparam int GRID_DIV  = ALT_STEP * TEMP_STEP;
  localparam int DIV       = GRID_DIV / 64;
  localparam int RND_BIAS  = (GRID_DIV / 2) / 64;
  localparam logic [22:0] RECIP = 23'((64'd1 << 32) / DIV);

  logic en;
  logic b1_v, b2_v, b3_v, b4_v, b5_v, out_v;
  logic b1_oor, b2_oor, b3_oor, b4_oor, b5_oor;

  logic [ENTRY_BITS-1:0] c00, c01, c10, c11;
  logic [FA_BITS-1:0]    wa0, wa1;
  logic [FT_BITS-1:0]    b1_wt0, b1_wt1, b2_wt0, b2_wt1;
  logic [20:0]           a0, a1, a2, a3;
  logic [25:0]           p0, p1, p2, p3;
  logic [27:0]           b4_y, b5_y;
  logic [RATE_BITS-1:0]  b5_q0;
  logic [50:0]           q_prod;
  logic [27:0]           rem;
  logic [RATE_BITS-1:0]  rate;
  logic                  out_oor;

  logic [GRID_BITS-1:0]  row1, col1;

  assign en  = !out_v || out_ch.ready;
  assign pop = en && !q_stat.empty;

  assign row1   = head.row + 1'b1;
  assign col1   = head.col + 1'b1;
  assign q_prod = 51'(b4_y) * 51'(RECIP);
  assign rem    = b5_y - 28'(b5_q0) * 28'(DIV);

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v  <= 1'b0;
      b2_v  <= 1'b0;
      b3_v  <= 1'b0;
      b4_v  <= 1'b0;
      b5_v  <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      b1_v  <= !q_stat.empty;
      b2_v  <= b1_v;
      b3_v  <= b2_v;
      b4_v  <= b3_v;
      b5_v  <= b4_v;
      out_v <= b5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c00    <= climb_entry(head.row, head.col);
      c01    <= climb_entry(head.row, col1);
      c10    <= climb_entry(row1, head.col);
      c11    <= climb_entry(row1, col1);
      wa0    <= FA_BITS'(ALT_STEP) - head.fa;
      wa1    <= head.fa;
      b1_wt0 <= FT_BITS'(TEMP_STEP) - head.ft;
      b1_wt1 <= head.ft;
      b1_oor <= head.oor;

      a0     <= 21'(c00) * 21'(wa0);
      a1     <= 21'(c01) * 21'(wa0);
      a2     <= 21'(c10) * 21'(wa1);
      a3     <= 21'(c11) * 21'(wa1);
      b2_wt0 <= b1_wt0;
      b2_wt1 <= b1_wt1;
      b2_oor <= b1_oor;

      p0     <= 26'(a0) * 26'(b2_wt0);
      p1     <= 26'(a1) * 26'(b2_wt1);
      p2     <= 26'(a2) * 26'(b2_wt0);
      p3     <= 26'(a3) * 26'(b2_wt1);
      b3_oor <= b2_oor;

      b4_y   <= ((28'(p0) + 28'(p1) + 28'(p2) + 28'(p3)) << 2) + 28'(RND_BIAS);
      b4_oor <= b3_oor;

      b5_q0  <= q_prod[32+RATE_BITS-1:32];
      b5_y   <= b4_y;
      b5_oor <= b4_oor;

      rate    <= b5_oor ? '0 : b5_q0 + RATE_BITS'(rem >= 28'(DIV));
      out_oor <= b5_oor;
    end
  end

  assign out_ch.valid        = out_v;
  assign out_ch.climb_rate   = rate;
  assign out_ch.out_of_range = out_oor;

endmodule

// ----- design/bilinear_table_interpolator.sv -----
// bilinear climb-rate lookup on a fixed altitude x temperature chart
// in_ch carries one query per transaction: altitude (feet, unsigned) and
//   temperature (degrees, signed); out_ch returns one transaction per query
//   with climb_rate in 1/256 ft/min, rounded to nearest, and out_of_range
// a query off the chart returns climb_rate 0 with out_of_range set
// a query passes the front register, one queue slot, 5 back stages and
//   the output register on its way to a valid result
// throughput: one query per cycle, sustained while the receiver stays ready;
//   the two-deep queue keeps the front and back stalls apart
// reset (rst, synchronous) empties the front stage, queue and back pipeline;
//   the chart is constant and needs no loading
// when the receiver stalls the back pipeline freezes in place, the queue
//   fills, and in_ch.ready drops once the front stage also holds a query;
//   nothing is dropped or repeated
module bilinear_table_interpolator import bti_pkg::*; #(
  parameter int ALT_ROWS  = 6,
  parameter int TEMP_COLS = 4
) (
  input  logic      clk,
  input  logic      rst,
  bti_in_if.sink    in_ch,
  bti_out_if.source out_ch
);

  // front to back queue wiring
  logic    push;
  logic    pop;
  item_t   push_item;
  item_t   head;
  q_stat_t q_stat;

  // front: range check, bracketing and fractions
  bti_front #(
    .ALT_ROWS  (ALT_ROWS),
    .TEMP_COLS (TEMP_COLS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  // short queue so front and back stall independently
  bti_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // back: corner fetch, weighting, sum and rounded divide
  bti_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // error results always carry a zero rate
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.out_of_range |-> out_ch.climb_rate == '0)
    else $error("out-of-range result with nonzero rate");

  // the chart maximum bounds every interpolated rate
  a_rate_max: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.climb_rate <= RATE_BITS'(212480))
    else $error("climb rate above chart maximum");

  // no write into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("queue overflow");

  // no read from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("queue underflow");

endmodule

// ----- tb/tb_bilinear_table_interpolator.sv -----
module tb_bilinear_table_interpolator import bti_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // chart geometry, matching the block's defaults
  localparam int ALT_ROWS  = 6;
  localparam int TEMP_COLS = 4;

  // highest on-chart altitude and temperature
  localparam int ALT_TOP  = (ALT_ROWS - 1) * ALT_STEP;
  localparam int TEMP_TOP = TEMP_BASE + (TEMP_COLS - 1) * TEMP_STEP;

  // cycles to let pass after the last result (pipeline is 8 deep)
  localparam int SETTLE_CYCLES = 20;

  // climb rates in ft/min, rows are altitude, columns temperature
  localparam int unsigned CLIMB_CHART [ALT_ROWS][TEMP_COLS] = '{
    '{830, 770, 705, 640},
    '{720, 655, 595, 535},
    '{645, 585, 525, 465},
    '{530, 475, 415, 360},
    '{420, 365, 310, 250},
    '{310, 255, 200, 145}
  };

  // one predicted result transaction
  typedef struct packed {
    logic [RATE_BITS-1:0] climb_rate;
    logic                 out_of_range;
  } climb_result_t;

  logic clk;
  logic rst;

  bti_in_if  in_ch ();
  bti_out_if out_ch ();

  bilinear_table_interpolator #(
    .ALT_ROWS  (ALT_ROWS),
    .TEMP_COLS (TEMP_COLS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predicted results, oldest first
  climb_result_t expected_rates[$];
  climb_result_t want_result;
  int            error_count;

  // idle odds in sixteenths: sender gap per query, receiver stall per cycle
  int            send_idle_chance;
  int            sink_stall_chance;
  int            stall_left;

  // free-running clock, 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // climb rate predictor: bracket the query on the grid, weight the four
  // corners by distance, scale to 1/256 ft/min and round half up
  function automatic climb_result_t predict_climb(
    input logic [ALT_BITS-1:0]         alt,
    input logic signed [TEMP_BITS-1:0] temp
  );
    longint        alt_ft;
    longint        temp_off;
    longint        row;
    longint        col;
    longint        fa;
    longint        ft;
    longint        acc;
    climb_result_t res;
    alt_ft   = longint'(alt);
    temp_off = longint'(temp) - TEMP_BASE;
    res      = '0;
    // off the chart: zero rate and the error flag
    if (alt_ft > ALT_TOP || temp_off < 0 || temp_off > TEMP_TOP - TEMP_BASE) begin
      res.out_of_range = 1'b1;
      return res;
    end
    // a breakpoint opens the interval above it; the top edge stays in the last cell
    row = alt_ft / ALT_STEP;
    if (row > ALT_ROWS - 2) begin
      row = ALT_ROWS - 2;
    end
    fa  = alt_ft - row * ALT_STEP;
    col = temp_off / TEMP_STEP;
    if (col > TEMP_COLS - 2) begin
      col = TEMP_COLS - 2;
    end
    ft  = temp_off - col * TEMP_STEP;
    acc = longint'(CLIMB_CHART[row][col])         * (ALT_STEP - fa) * (TEMP_STEP - ft)
        + longint'(CLIMB_CHART[row][col + 1])     * (ALT_STEP - fa) * ft
        + longint'(CLIMB_CHART[row + 1][col])     * fa * (TEMP_STEP - ft)
        + longint'(CLIMB_CHART[row + 1][col + 1]) * fa * ft;
    res.climb_rate = RATE_BITS'((acc * 256 + (ALT_STEP * TEMP_STEP) / 2)
                                / (ALT_STEP * TEMP_STEP));
    return res;
  endfunction

  // receiver: ready drops in bursts when stalls are enabled
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b1;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (sink_stall_chance != 0 && $urandom_range(0, 15) < sink_stall_chance) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(1, 6) - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // result checker: every result transaction against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_rates.size() == 0) begin
        $display("%0t: result with none expected: climb_rate %0d out_of_range %0b",
                 $time, out_ch.climb_rate, out_ch.out_of_range);
        error_count++;
      end else begin
        want_result = expected_rates.pop_front();
        if (out_ch.climb_rate !== want_result.climb_rate) begin
          $display("%0t: climb_rate mismatch: expected %0d, actual %0d",
                   $time, want_result.climb_rate, out_ch.climb_rate);
          error_count++;
        end
        if (out_ch.out_of_range !== want_result.out_of_range) begin
          $display("%0t: out_of_range mismatch: expected %0b, actual %0b",
                   $time, want_result.out_of_range, out_ch.out_of_range);
          error_count++;
        end
      end
    end
  end

  // sends one query transaction; the prediction is queued once it is accepted
  task automatic send_query(
    input logic [ALT_BITS-1:0]         alt,
    input logic signed [TEMP_BITS-1:0] temp
  );
    if (send_idle_chance != 0 && $urandom_range(0, 15) < send_idle_chance) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.altitude    <= alt;
    in_ch.temperature <= temp;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    expected_rates.push_back(predict_climb(alt, temp));
  endtask

  // sender goes quiet until every predicted result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_rates.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic set_idling(input int send_chance, input int stall_chance);
    send_idle_chance  = send_chance;
    sink_stall_chance = stall_chance;
  endtask

  // the low chart corner and other breakpoints: upper bracket, zero fraction
  task automatic test_breakpoints();
    send_query(14'd0, -7'sd20);
    send_query(14'd0, 7'sd0);
    send_query(14'd2000, -7'sd20);
    send_query(14'd4000, 7'sd20);
    send_query(14'd8000, 7'sd0);
    send_query(14'd6000, 7'sd20);
  endtask

  // top edges use the last cell with a full fraction, plus interior points
  task automatic test_top_edge();
    send_query(14'(ALT_TOP), -7'sd20);
    send_query(14'd0, 7'(TEMP_TOP));
    send_query(14'(ALT_TOP), 7'(TEMP_TOP));
    send_query(14'(ALT_TOP - 1), 7'(TEMP_TOP - 1));
    send_query(14'd1000, -7'sd10);
    send_query(14'd5000, 7'sd17);
    send_query(14'd1, -7'sd19);
    send_query(14'd9999, 7'sd39);
  endtask

  // off the chart on each side, and the field extremes
  task automatic test_off_chart();
    send_query(14'(ALT_TOP + 1), 7'sd0);
    send_query(14'd0, -7'sd21);
    send_query(14'd0, 7'(TEMP_TOP + 1));
    send_query(14'h3FFF, -7'sd64);
    send_query(14'h3FFF, 7'sd63);
    send_query(14'd0, 7'sd63);
    send_query(14'd5000, -7'sd64);
    send_query(14'h2AAA, 7'sd10);
  endtask

  // random queries: mostly on the chart, some on breakpoints, some anywhere
  task automatic test_random_queries(input int count);
    logic [ALT_BITS-1:0]         alt;
    logic signed [TEMP_BITS-1:0] temp;
    int                          pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 15);
      if (pick < 10) begin
        alt  = ALT_BITS'($urandom_range(0, ALT_TOP));
        temp = TEMP_BITS'(int'($urandom_range(0, TEMP_TOP - TEMP_BASE)) + TEMP_BASE);
      end else if (pick < 13) begin
        // snap one or both axes onto a grid line
        alt  = ALT_BITS'(ALT_STEP * $urandom_range(0, ALT_ROWS - 1));
        temp = TEMP_BITS'(int'($urandom_range(0, TEMP_TOP - TEMP_BASE)) + TEMP_BASE);
        if ($urandom_range(0, 1) != 0) begin
          temp = TEMP_BITS'(TEMP_BASE + TEMP_STEP * int'($urandom_range(0, TEMP_COLS - 1)));
        end
      end else begin
        // anywhere in the field ranges, mostly off the chart
        alt  = ALT_BITS'($urandom_range(0, (1 << ALT_BITS) - 1));
        temp = TEMP_BITS'($urandom_range(0, (1 << TEMP_BITS) - 1));
      end
      send_query(alt, temp);
    end
  endtask

  // a burst of queries, a full stop until the pipeline empties, then another burst
  task automatic test_pause_and_resume();
    test_random_queries(40);
    drain_results();
    test_random_queries(40);
  endtask

  initial begin
    // block inputs known from time zero
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.altitude    = '0;
    in_ch.temperature = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part, no idling, then with idling
    test_breakpoints();
    set_idling(6, 6);
    test_top_edge();
    test_off_chart();

    // random part across idling mixes, with stretches free of it
    set_idling(4, 4);
    test_random_queries(500);
    set_idling(0, 0);
    test_random_queries(300);
    set_idling(10, 2);
    test_random_queries(250);
    set_idling(2, 10);
    test_random_queries(250);
    set_idling(5, 5);
    test_pause_and_resume();

    // last stretch runs with no idling on either side
    set_idling(0, 0);
    test_random_queries(370);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog for a hung handshake
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
